// ----- sv/i2cms_pkg.sv -----
// i2cms_pkg: shared types and field widths for the i2c master batch sequencer
// no dependencies; imported by the channel interfaces and every module

package i2cms_pkg;

   // payload field widths, fixed by the item format
   localparam int OP_W   = 2;
   localparam int LEN_W  = 7;
   localparam int BYTE_W = 8;
   localparam int ADDR_W = 7;
   localparam int STAT_W = 4;
   localparam int CMD_W  = 3;
   localparam int IDX_W  = 6;

   typedef enum logic [OP_W-1:0] {
      OP_ADD_DESC = 2'd0,
      OP_ADD_BYTE = 2'd1,
      OP_START    = 2'd2,
      OP_STATUS   = 2'd3
   } op_type;

   // bus status codes reported by the bus side
   typedef enum logic [STAT_W-1:0] {
      BS_START        = 4'd0,
      BS_REP_START    = 4'd1,
      BS_MT_SLA_ACK   = 4'd2,
      BS_MT_SLA_NACK  = 4'd3,
      BS_MT_DATA_ACK  = 4'd4,
      BS_MR_SLA_ACK   = 4'd5,
      BS_MR_DATA_ACK  = 4'd6,
      BS_MR_DATA_NACK = 4'd7,
      BS_OTHER        = 4'd8
   } bus_status_type;

   typedef enum logic [CMD_W-1:0] {
      CMD_NONE    = 3'd0,
      CMD_START   = 3'd1,
      CMD_ADDR_W  = 3'd2,
      CMD_ADDR_R  = 3'd3,
      CMD_SEND    = 3'd4,
      CMD_RX_ACK  = 3'd5,
      CMD_RX_NACK = 3'd6,
      CMD_STOP    = 3'd7
   } bus_cmd_type;

   typedef enum logic {
      SEQ_IDLE = 1'b0,
      SEQ_EXEC = 1'b1
   } seq_state_type;

   // controller to datapath
   typedef struct packed {
      logic capture;   // latch the request and launch the store reads
      logic execute;   // evaluate the item, update state, load the result register
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_full;  // result register holds a transfer that is not taken this cycle
   } dp_status_type;

endpackage

// ----- sv/i2cms_if.sv -----
// i2cms_req_if / i2cms_rsp_if: valid/ready channels for requests and results
// depends on i2cms_pkg for the field widths

interface i2cms_req_if import i2cms_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   operation;
   logic              is_write;
   logic [LEN_W-1:0]  length;
   logic [BYTE_W-1:0] data_byte;
   logic [ADDR_W-1:0] slave_address;
   logic [STAT_W-1:0] bus_status;

   modport source (output valid, operation, is_write, length, data_byte, slave_address,
                   bus_status, input ready);
   modport sink   (input valid, operation, is_write, length, data_byte, slave_address,
                   bus_status, output ready);
endinterface

interface i2cms_rsp_if import i2cms_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  bus_command;
   logic [BYTE_W-1:0] send_byte;
   logic              read_valid;
   logic [BYTE_W-1:0] read_byte;
   logic [IDX_W-1:0]  read_index;
   logic              batch_done;
   logic              unexpected;

   modport source (output valid, bus_command, send_byte, read_valid, read_byte, read_index,
                   batch_done, unexpected, input ready);
   modport sink   (input valid, bus_command, send_byte, read_valid, read_byte, read_index,
                   batch_done, unexpected, output ready);
endinterface

// ----- sv/i2cms_ctrl.sv -----
// i2cms_ctrl: two-state sequencing controller, one item at a time
// depends on i2cms_pkg for the state, command and status types

module i2cms_ctrl import i2cms_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output ctrl_cmd_type  cmd,
   input  dp_status_type status
);

   seq_state_type state_ff;
   seq_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         SEQ_IDLE: begin
            if (req_valid) state_in = SEQ_EXEC;
         end
         SEQ_EXEC: begin
            if (!status.out_full) state_in = SEQ_IDLE;
         end
         default: state_in = SEQ_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready   = 1'b0;
      cmd.capture = 1'b0;
      cmd.execute = 1'b0;
      unique case (state_ff)
         SEQ_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         SEQ_EXEC: begin
            cmd.execute = !status.out_full;
         end
         default: ;
      endcase
   end

endmodule

// ----- sv/i2cms_datapath.sv -----
// i2cms_datapath: descriptor and write byte stores, batch state and result register
// depends on i2cms_pkg; driven by i2cms_ctrl through capture and execute

module i2cms_datapath import i2cms_pkg::*; #(
   parameter int MAX_TRANSACTIONS = 16,
   parameter int MAX_LENGTH       = 64,
   parameter int BYTE_STORE_DEPTH = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  ctrl_cmd_type      cmd,
   output dp_status_type     status,
   input  logic [OP_W-1:0]   operation,
   input  logic              is_write,
   input  logic [LEN_W-1:0]  length,
   input  logic [BYTE_W-1:0] data_byte,
   input  logic [ADDR_W-1:0] slave_address,
   input  logic [STAT_W-1:0] bus_status,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   output logic [CMD_W-1:0]  rsp_bus_command,
   output logic [BYTE_W-1:0] rsp_send_byte,
   output logic              rsp_read_valid,
   output logic [BYTE_W-1:0] rsp_read_byte,
   output logic [IDX_W-1:0]  rsp_read_index,
   output logic              rsp_batch_done,
   output logic              rsp_unexpected
);

   localparam int TIDX_W   = (MAX_TRANSACTIONS > 1) ? $clog2(MAX_TRANSACTIONS) : 1;
   localparam int CNT_W    = $clog2(MAX_TRANSACTIONS + 1);
   localparam int BAW      = $clog2(BYTE_STORE_DEPTH);
   localparam int BLP_W    = $clog2(BYTE_STORE_DEPTH + 1);
   localparam int LEN_TOP  = (1 << LEN_W) - 1;
   localparam int LEN_CAP  = (MAX_LENGTH > LEN_TOP) ? LEN_TOP : MAX_LENGTH;
   localparam int BRP_SPAN = $clog2(MAX_TRANSACTIONS * LEN_CAP + LEN_CAP + 1);
   localparam int POS_W    = (BRP_SPAN > BLP_W) ? BRP_SPAN : BLP_W;
   localparam logic [LEN_W:0]     MAXL    = (LEN_W + 1)'(MAX_LENGTH);
   localparam logic [POS_W-1:0]   DEPTH_P = POS_W'(BYTE_STORE_DEPTH);
   localparam logic [BLP_W-1:0]   DEPTH_L = BLP_W'(BYTE_STORE_DEPTH);
   localparam logic [CNT_W-1:0]   MAXT_C  = CNT_W'(MAX_TRANSACTIONS);

   // stores: descriptor entry is {is_write, clamped length}
   logic [LEN_W:0]      desc_mem [MAX_TRANSACTIONS];
   logic [BYTE_W-1:0]   byte_mem [BYTE_STORE_DEPTH];

   // captured request
   op_type              item_op_ff;
   logic                item_dir_ff;
   logic [LEN_W-1:0]    item_len_ff;
   logic [BYTE_W-1:0]   item_data_ff;
   logic [ADDR_W-1:0]   item_addr_ff;
   logic [STAT_W-1:0]   item_status_ff;
   logic [POS_W-1:0]    pos_ff;
   logic [LEN_W:0]      desc_rd_ff;
   logic [BYTE_W-1:0]   byte_rd_ff;

   // batch state
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [BLP_W-1:0]    blp_ff, blp_in;
   logic [TIDX_W-1:0]   cur_ff, cur_in;
   logic [CNT_W-1:0]    left_ff, left_in;
   logic [LEN_W-1:0]    offset_ff, offset_in;
   logic [POS_W-1:0]    brp_ff, brp_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [CMD_W-1:0]    rsp_cmd_ff;
   logic [BYTE_W-1:0]   rsp_sbyte_ff;
   logic                rsp_rvalid_ff;
   logic [BYTE_W-1:0]   rsp_rbyte_ff;
   logic [IDX_W-1:0]    rsp_ridx_ff;
   logic                rsp_done_ff;
   logic                rsp_unexp_ff;

   logic [POS_W-1:0]    pos_cap;
   logic [LEN_W-1:0]    clamp_len;
   logic                desc_we, byte_we;
   logic                active, wr, do_finish;
   logic [LEN_W-1:0]    tlen, off_inc, off_wr;
   logic [POS_W-1:0]    fin_brp;
   logic [TIDX_W-1:0]   fin_cur;
   logic [CNT_W-1:0]    fin_left;
   bus_cmd_type         res_cmd;
   logic [BYTE_W-1:0]   res_sbyte;
   logic                res_rvalid;
   logic [BYTE_W-1:0]   res_rbyte;
   logic [IDX_W-1:0]    res_ridx;
   logic                res_done;
   logic                res_unexp;

   // byte position for a send, taken from the incoming status so the store read
   // can start at the accepting edge
   assign pos_cap = brp_ff + POS_W'(offset_ff)
                  + POS_W'(bus_status == BS_MT_DATA_ACK);

   assign clamp_len = (item_len_ff == '0)            ? LEN_W'(1)
                    : ({1'b0, item_len_ff} > MAXL)   ? MAXL[LEN_W-1:0]
                    : item_len_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_op_ff     <= op_type'(operation);
         item_dir_ff    <= is_write;
         item_len_ff    <= length;
         item_data_ff   <= data_byte;
         item_addr_ff   <= slave_address;
         item_status_ff <= bus_status;
         pos_ff         <= pos_cap;
         desc_rd_ff     <= desc_mem[cur_ff];
         if (pos_cap < DEPTH_P) byte_rd_ff <= byte_mem[pos_cap[BAW-1:0]];
      end
      if (desc_we) desc_mem[count_ff[TIDX_W-1:0]] <= {item_dir_ff, clamp_len};
      if (byte_we) byte_mem[blp_ff[BAW-1:0]] <= item_data_ff;
   end

   assign active   = (left_ff != '0);
   assign wr       = desc_rd_ff[LEN_W];
   assign tlen     = desc_rd_ff[LEN_W-1:0];
   assign off_inc  = offset_ff + LEN_W'(1);
   assign off_wr   = (item_status_ff == BS_MT_DATA_ACK) ? off_inc : offset_ff;
   assign fin_brp  = brp_ff + (wr ? POS_W'(tlen) : '0);
   assign fin_cur  = cur_ff + TIDX_W'(1);
   assign fin_left = left_ff - CNT_W'(1);

   always_comb begin
      count_in   = count_ff;
      blp_in     = blp_ff;
      cur_in     = cur_ff;
      left_in    = left_ff;
      offset_in  = offset_ff;
      brp_in     = brp_ff;
      addr_in    = addr_ff;
      desc_we    = 1'b0;
      byte_we    = 1'b0;
      do_finish  = 1'b0;
      res_cmd    = CMD_NONE;
      res_sbyte  = '0;
      res_rvalid = 1'b0;
      res_rbyte  = '0;
      res_ridx   = '0;
      res_done   = 1'b0;
      res_unexp  = 1'b0;

      unique case (item_op_ff)
         OP_ADD_DESC: begin
            if (!active && count_ff < MAXT_C) begin
               desc_we  = cmd.execute;
               count_in = count_ff + CNT_W'(1);
            end
         end
         OP_ADD_BYTE: begin
            if (!active && blp_ff < DEPTH_L) begin
               byte_we = cmd.execute;
               blp_in  = blp_ff + BLP_W'(1);
            end
         end
         OP_START: begin
            if (!active) begin
               addr_in   = item_addr_ff;
               cur_in    = '0;
               offset_in = '0;
               brp_in    = '0;
               left_in   = count_ff;
               if (count_ff != '0) res_cmd = CMD_START;
               else                res_done = 1'b1;
            end
         end
         OP_STATUS: begin
            if (!active) begin
               res_unexp = 1'b1;
            end else begin
               unique case (item_status_ff)
                  BS_START, BS_REP_START: begin
                     res_cmd   = wr ? CMD_ADDR_W : CMD_ADDR_R;
                     res_sbyte = {addr_ff, ~wr};
                  end
                  BS_MT_SLA_NACK: begin
                     if (!wr) res_unexp = 1'b1;
                     else     res_cmd   = CMD_START;
                  end
                  BS_MT_SLA_ACK, BS_MT_DATA_ACK: begin
                     if (!wr) begin
                        res_unexp = 1'b1;
                     end else if (off_wr >= tlen) begin
                        do_finish = 1'b1;
                     end else begin
                        offset_in = off_wr;
                        res_cmd   = CMD_SEND;
                        res_sbyte = (pos_ff < DEPTH_P) ? byte_rd_ff : '0;
                     end
                  end
                  BS_MR_SLA_ACK: begin
                     if (wr) res_unexp = 1'b1;
                     else    res_cmd = (tlen == off_inc) ? CMD_RX_NACK : CMD_RX_ACK;
                  end
                  BS_MR_DATA_ACK: begin
                     // ack on a byte that should have been the last one is refused
                     if (wr || off_inc >= tlen) begin
                        res_unexp = 1'b1;
                     end else begin
                        res_rvalid = 1'b1;
                        res_rbyte  = item_data_ff;
                        res_ridx   = offset_ff[IDX_W-1:0];
                        offset_in  = off_inc;
                        res_cmd    = (tlen == off_inc + LEN_W'(1)) ? CMD_RX_NACK : CMD_RX_ACK;
                     end
                  end
                  BS_MR_DATA_NACK: begin
                     if (wr) begin
                        res_unexp = 1'b1;
                     end else begin
                        res_rvalid = 1'b1;
                        res_rbyte  = item_data_ff;
                        res_ridx   = offset_ff[IDX_W-1:0];
                        do_finish  = 1'b1;
                     end
                  end
                  default: res_unexp = 1'b1;
               endcase
            end
         end
         default: ;
      endcase

      // close the current transaction: repeated start, or stop at the end of the batch
      if (do_finish) begin
         brp_in    = fin_brp;
         cur_in    = fin_cur;
         left_in   = fin_left;
         offset_in = '0;
         if (fin_left != '0) begin
            res_cmd = CMD_START;
         end else begin
            count_in = '0;
            blp_in   = '0;
            brp_in   = '0;
            cur_in   = '0;
            res_done = 1'b1;
            res_cmd  = CMD_STOP;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         blp_ff    <= '0;
         cur_ff    <= '0;
         left_ff   <= '0;
         offset_ff <= '0;
         brp_ff    <= '0;
         addr_ff   <= '0;
      end else if (cmd.execute) begin
         count_ff  <= count_in;
         blp_ff    <= blp_in;
         cur_ff    <= cur_in;
         left_ff   <= left_in;
         offset_ff <= offset_in;
         brp_ff    <= brp_in;
         addr_ff   <= addr_in;
      end
   end

   assign rsp_valid_in = cmd.execute | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         rsp_cmd_ff    <= res_cmd;
         rsp_sbyte_ff  <= res_sbyte;
         rsp_rvalid_ff <= res_rvalid;
         rsp_rbyte_ff  <= res_rbyte;
         rsp_ridx_ff   <= res_ridx;
         rsp_done_ff   <= res_done;
         rsp_unexp_ff  <= res_unexp;
      end
   end

   assign status.out_full = rsp_valid_ff & ~rsp_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_bus_command = rsp_cmd_ff;
   assign rsp_send_byte   = rsp_sbyte_ff;
   assign rsp_read_valid  = rsp_rvalid_ff;
   assign rsp_read_byte   = rsp_rbyte_ff;
   assign rsp_read_index  = rsp_ridx_ff;
   assign rsp_batch_done  = rsp_done_ff;
   assign rsp_unexpected  = rsp_unexp_ff;

endmodule

// ----- sv/i2c_master_batch_sequencer_top.sv -----
// i2c_master_batch_sequencer_top: i2c master sequencer for a batch of transactions
// depends on i2cms_pkg, i2cms_req_if / i2cms_rsp_if, i2cms_ctrl and i2cms_datapath
//
//   channel    direction   carries
//   req_chan   in          load descriptor / load write byte / start batch / bus status
//   rsp_chan   out         bus command with byte, received byte and index, done, unexpected
//
// each request is handled in order: the accepting edge latches it and reads both stores,
// and the execute edge updates the batch state and loads the result register
// a request can be accepted while the previous result still waits in the result register
// a stalled result holds the execute step of the next request until it is taken
// synchronous active high reset clears the batch state; the stores are not cleared

module i2c_master_batch_sequencer_top import i2cms_pkg::*; #(
   parameter int MAX_TRANSACTIONS = 16,
   parameter int MAX_LENGTH       = 64,
   parameter int BYTE_STORE_DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   i2cms_req_if.sink   req_chan,
   i2cms_rsp_if.source rsp_chan
);

   // controller and datapath meet only through these two groups
   ctrl_cmd_type  seq_cmd;
   dp_status_type dp_status;

   i2cms_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .cmd       (seq_cmd),
      .status    (dp_status)
   );

   i2cms_datapath #(
      .MAX_TRANSACTIONS (MAX_TRANSACTIONS),
      .MAX_LENGTH       (MAX_LENGTH),
      .BYTE_STORE_DEPTH (BYTE_STORE_DEPTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (seq_cmd),
      .status          (dp_status),
      .operation       (req_chan.operation),
      .is_write        (req_chan.is_write),
      .length          (req_chan.length),
      .data_byte       (req_chan.data_byte),
      .slave_address   (req_chan.slave_address),
      .bus_status      (req_chan.bus_status),
      .rsp_ready       (rsp_chan.ready),
      .rsp_valid       (rsp_chan.valid),
      .rsp_bus_command (rsp_chan.bus_command),
      .rsp_send_byte   (rsp_chan.send_byte),
      .rsp_read_valid  (rsp_chan.read_valid),
      .rsp_read_byte   (rsp_chan.read_byte),
      .rsp_read_index  (rsp_chan.read_index),
      .rsp_batch_done  (rsp_chan.batch_done),
      .rsp_unexpected  (rsp_chan.unexpected)
   );

   // one request in flight: no second transfer straight after an accepted one
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("request accepted while another is in flight");

   // a result is never loaded over one that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      seq_cmd.execute |-> !dp_status.out_full)
      else $error("result register overwritten");

   // every executed request shows a result on the next cycle
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      seq_cmd.execute |=> rsp_chan.valid)
      else $error("executed request produced no result");

   // an unhandled status never also closes the batch
   a_done_vs_unexp: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> !(rsp_chan.batch_done && rsp_chan.unexpected))
      else $error("batch done flagged together with unexpected status");

endmodule
